>>> rtl/dqmc_pkg.sv
// shared types and constants for the dual quadrature move counter
package dqmc_pkg;

  // function codes of an input word
  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_ARM    = 2'd1,
    FUNC_CHECK  = 2'd2
  } func_t;

  localparam int unsigned FUNC_BITS  = 2;
  localparam int unsigned PIN_BITS   = 4;
  localparam int unsigned DIST_BITS  = 31;
  localparam int unsigned OUT_CNT_BITS = 32;

  // encoder 0 owns pin bits 0 (A) and 2 (B)
  localparam logic [PIN_BITS-1:0] ENC0_PINS  = 4'h5;
  localparam logic [PIN_BITS-1:0] PINS_RESET = 4'hF;

endpackage

>>> rtl/dqmc_arrival.sv
// arrival test: distance moved since the start count against the armed distance
module dqmc_arrival #(
  parameter int COUNT_BITS = 32
) (
  input  logic [COUNT_BITS-1:0]          count,
  input  logic [COUNT_BITS-1:0]          start_count,
  input  logic                           start_captured,
  input  logic [dqmc_pkg::DIST_BITS-1:0] distance,
  output logic [COUNT_BITS-1:0]          start_used,
  output logic                           reached
);

  localparam int CMP_W = (COUNT_BITS > 31) ? COUNT_BITS : 31;

  logic [COUNT_BITS-1:0] diff;
  logic [COUNT_BITS-1:0] mag;

  // a fresh start is the count itself, so the first check sees zero movement
  assign start_used = start_captured ? start_count : count;
  assign diff       = count - start_used;
  assign mag        = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
  assign reached    = CMP_W'(mag) >= CMP_W'(distance);

endmodule

>>> rtl/dual_quadrature_move_counter_core.sv
// top level of the dual quadrature move counter
//
// keeps a wrapping step count for each of two quadrature encoders and a pending
// move per motor. a sample word counts encoder 0 when its pins changed since the
// previous sample and encoder 1 otherwise: equal A and B levels count up,
// unequal levels count down. an arm word stores a move distance (zero disarms);
// the first check after arming captures the current count as the start, and a
// check raises stop and disarms once the count has moved the distance either
// way. every input word yields exactly one result word carrying both counts and
// the armed mask. a word passes an input register, then one pass through the
// counter increment and the arrival compare into the result register, where
// out_valid rises; a stalled result keeps the word in the input register until
// the result register is free, and one word is taken every cycle as long as
// the result side keeps up. the result register frees itself in the cycle it
// is taken, so a stalled result holds only one word in each stage.
module dual_quadrature_move_counter_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dqmc_pkg::FUNC_BITS-1:0]    in_func,
  input  logic [dqmc_pkg::PIN_BITS-1:0]     in_pin_levels,
  input  logic                              in_motor_sel,
  input  logic [dqmc_pkg::DIST_BITS-1:0]    in_distance,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_stop,
  output logic                              out_stopped_motor,
  output logic signed [dqmc_pkg::OUT_CNT_BITS-1:0] out_count_zero,
  output logic signed [dqmc_pkg::OUT_CNT_BITS-1:0] out_count_one,
  output logic [1:0]                        out_armed_mask
);

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // input register
  logic                           s1_valid_r;
  logic [dqmc_pkg::FUNC_BITS-1:0] s1_func_r;
  logic [dqmc_pkg::PIN_BITS-1:0]  s1_pins_r;
  logic                           s1_motor_r;
  logic [dqmc_pkg::DIST_BITS-1:0] s1_dist_r;
  logic                           s1_fire;

  // block state
  logic [COUNT_BITS-1:0]          step_r  [2];
  logic [COUNT_BITS-1:0]          step_nxt[2];
  logic [dqmc_pkg::DIST_BITS-1:0] dist_r  [2];
  logic [dqmc_pkg::DIST_BITS-1:0] dist_nxt[2];
  logic [COUNT_BITS-1:0]          start_r  [2];
  logic [COUNT_BITS-1:0]          start_nxt[2];
  logic [1:0]                     cap_r;
  logic [1:0]                     cap_nxt;
  logic [dqmc_pkg::PIN_BITS-1:0]  prev_pins_r;
  logic [dqmc_pkg::PIN_BITS-1:0]  prev_pins_nxt;

  // result register
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           stop_r;
  logic                           stop_nxt;
  logic                           smotor_r;
  logic                           smotor_nxt;
  logic [COUNT_BITS-1:0]          cnt0_r;
  logic [COUNT_BITS-1:0]          cnt1_r;
  logic [1:0]                     armed_r;
  logic [1:0]                     armed_nxt;

  // per-word decode
  logic                           enc;
  logic                           pin_a;
  logic                           pin_b;
  logic [COUNT_BITS-1:0]          start_used;
  logic                           reached;

  // the input stage moves on whenever the result register is free or drained
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r  <= in_func;
      s1_pins_r  <= in_pin_levels;
      s1_motor_r <= in_motor_sel;
      s1_dist_r  <= in_distance;
    end
  end

  // encoder 0 wins whenever any of its pins moved
  assign enc   = ((s1_pins_r ^ prev_pins_r) & dqmc_pkg::ENC0_PINS) == '0;
  assign pin_a = s1_pins_r[{1'b0, enc}];
  assign pin_b = s1_pins_r[{1'b1, enc}];

  // arrival test for the addressed motor
  dqmc_arrival #(
    .COUNT_BITS(COUNT_BITS)
  ) u_arrival (
    .count         (step_r[s1_motor_r]),
    .start_count   (start_r[s1_motor_r]),
    .start_captured(cap_r[s1_motor_r]),
    .distance      (dist_r[s1_motor_r]),
    .start_used    (start_used),
    .reached       (reached)
  );

  always_comb begin
    step_nxt      = step_r;
    dist_nxt      = dist_r;
    start_nxt     = start_r;
    cap_nxt       = cap_r;
    prev_pins_nxt = prev_pins_r;
    stop_nxt      = 1'b0;
    smotor_nxt    = 1'b0;
    case (s1_func_r)
      dqmc_pkg::FUNC_SAMPLE: begin
        step_nxt[enc] = (pin_a == pin_b) ? step_r[enc] + CNT_ONE : step_r[enc] - CNT_ONE;
        prev_pins_nxt = s1_pins_r;
      end
      dqmc_pkg::FUNC_ARM: begin
        dist_nxt[s1_motor_r] = s1_dist_r;
        cap_nxt[s1_motor_r]  = 1'b0;
      end
      dqmc_pkg::FUNC_CHECK: begin
        smotor_nxt = s1_motor_r;
        // a disarmed motor leaves everything alone
        if (dist_r[s1_motor_r] != '0) begin
          start_nxt[s1_motor_r] = start_used;
          cap_nxt[s1_motor_r]   = 1'b1;
          if (reached) begin
            stop_nxt             = 1'b1;
            dist_nxt[s1_motor_r] = '0;
            cap_nxt[s1_motor_r]  = 1'b0;
          end
        end
      end
      default: begin
        // unused code: no state change, stop stays low
      end
    endcase
    armed_nxt = {dist_nxt[1] != '0, dist_nxt[0] != '0};
  end

  // state commits only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r[0]   <= '0;
      step_r[1]   <= '0;
      dist_r[0]   <= '0;
      dist_r[1]   <= '0;
      start_r[0]  <= '0;
      start_r[1]  <= '0;
      cap_r       <= '0;
      prev_pins_r <= dqmc_pkg::PINS_RESET;
    end else if (s1_fire) begin
      step_r      <= step_nxt;
      dist_r      <= dist_nxt;
      start_r     <= start_nxt;
      cap_r       <= cap_nxt;
      prev_pins_r <= prev_pins_nxt;
    end
  end

  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      stop_r   <= stop_nxt;
      smotor_r <= smotor_nxt;
      cnt0_r   <= step_nxt[0];
      cnt1_r   <= step_nxt[1];
      armed_r  <= armed_nxt;
    end
  end

  // counts leave sign-extended or truncated to the 32-bit result field
  assign out_valid         = out_valid_r;
  assign out_stop          = stop_r;
  assign out_stopped_motor = smotor_r;
  assign out_count_zero    = dqmc_pkg::OUT_CNT_BITS'($signed(cnt0_r));
  assign out_count_one     = dqmc_pkg::OUT_CNT_BITS'($signed(cnt1_r));
  assign out_armed_mask    = armed_r;

  // a stop always leaves its motor disarmed
  a_stop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && stop_r |-> !armed_r[smotor_r])
    else $error("stop reported while motor still armed");

  // a captured start only exists for an armed motor
  a_cap_armed0: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r[0] |-> dist_r[0] != '0)
    else $error("start captured on disarmed motor 0");

  a_cap_armed1: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r[1] |-> dist_r[1] != '0)
    else $error("start captured on disarmed motor 1");

  // a sample word moves exactly one counter
  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_func_r == dqmc_pkg::FUNC_SAMPLE |=>
      ((step_r[0] != $past(step_r[0])) != (step_r[1] != $past(step_r[1]))))
    else $error("sample did not move exactly one counter");

  // counters hold on every other cycle
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_fire && s1_func_r == dqmc_pkg::FUNC_SAMPLE) |=>
      $stable(step_r[0]) && $stable(step_r[1]))
    else $error("counter changed without a sample word");

endmodule

>>> bench/tb_dual_quadrature_move_counter_core.sv
// self-checking testbench for the dual quadrature move counter core
`timescale 1ns / 1ps

module tb_dual_quadrature_move_counter_core;

  // the core runs at its default count width, the predictor follows it
  localparam int CNT_W = 32;
  // func code that the package leaves unused
  localparam logic [dqmc_pkg::FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
  // cycles with no word moving on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 3000;
  // cycles allowed after the last result for a stray word to show up
  localparam int unsigned DRAIN_CYCLES = 6;

  // one result word as the predictor sees it
  typedef struct packed {
    logic                              stop;
    logic                              motor;
    logic [dqmc_pkg::OUT_CNT_BITS-1:0] cnt0;
    logic [dqmc_pkg::OUT_CNT_BITS-1:0] cnt1;
    logic [1:0]                        armed;
  } move_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                              in_valid;
  logic                              in_ready;
  logic [dqmc_pkg::FUNC_BITS-1:0]    in_func;
  logic [dqmc_pkg::PIN_BITS-1:0]     in_pin_levels;
  logic                              in_motor_sel;
  logic [dqmc_pkg::DIST_BITS-1:0]    in_distance;

  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_stop;
  logic                              out_stopped_motor;
  logic signed [dqmc_pkg::OUT_CNT_BITS-1:0] out_count_zero;
  logic signed [dqmc_pkg::OUT_CNT_BITS-1:0] out_count_one;
  logic [1:0]                        out_armed_mask;

  // predictor state, mirrors the core after reset
  logic [CNT_W-1:0]               enc_count  [2] = '{default: '0};
  logic [dqmc_pkg::DIST_BITS-1:0] move_span  [2] = '{default: '0};
  logic [CNT_W-1:0]               start_mark [2] = '{default: '0};
  logic                           start_held [2] = '{default: 1'b0};
  logic [dqmc_pkg::PIN_BITS-1:0]  last_pins = dqmc_pkg::PINS_RESET;

  move_result_t pending_results[$];

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned stops_seen = 0;
  int unsigned quiet_cycles = 0;

  dual_quadrature_move_counter_core #(
    .COUNT_BITS(CNT_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_pin_levels    (in_pin_levels),
    .in_motor_sel     (in_motor_sel),
    .in_distance      (in_distance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_stop         (out_stop),
    .out_stopped_motor(out_stopped_motor),
    .out_count_zero   (out_count_zero),
    .out_count_one    (out_count_one),
    .out_armed_mask   (out_armed_mask)
  );

  always #10 clk = ~clk;

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // next state and result word for one accepted input word
  function automatic move_result_t predict_move_result(
      input logic [dqmc_pkg::FUNC_BITS-1:0] f,
      input logic [dqmc_pkg::PIN_BITS-1:0]  pins,
      input logic                           m,
      input logic [dqmc_pkg::DIST_BITS-1:0] d);
    move_result_t r;
    logic enc;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] mag;
    r = '0;
    case (f)
      dqmc_pkg::FUNC_SAMPLE: begin
        // encoder 0 wins whenever its own pins changed
        enc = (((pins ^ last_pins) & dqmc_pkg::ENC0_PINS) != '0) ? 1'b0 : 1'b1;
        if (pins[enc] == pins[enc + 2]) begin
          enc_count[enc] = enc_count[enc] + 1'b1;
        end else begin
          enc_count[enc] = enc_count[enc] - 1'b1;
        end
        last_pins = pins;
      end
      dqmc_pkg::FUNC_ARM: begin
        move_span[m] = d;
        start_held[m] = 1'b0;
      end
      dqmc_pkg::FUNC_CHECK: begin
        r.motor = m;
        if (move_span[m] != '0) begin
          if (!start_held[m]) begin
            start_mark[m] = enc_count[m];
            start_held[m] = 1'b1;
          end
          // wrapping distance from the start, either direction
          moved = enc_count[m] - start_mark[m];
          mag = moved[CNT_W-1] ? (~moved + 1'b1) : moved;
          if (mag >= {1'b0, move_span[m]}) begin
            r.stop = 1'b1;
            move_span[m] = '0;
            start_held[m] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.cnt0 = enc_count[0];
    r.cnt1 = enc_count[1];
    r.armed = {move_span[1] != '0, move_span[0] != '0};
    return r;
  endfunction

  // pin word that steps one encoder in the wanted direction
  function automatic logic [dqmc_pkg::PIN_BITS-1:0] step_pins(input logic enc,
                                                              input logic up);
    logic a;
    logic b;
    a = 1'($urandom);
    b = up ? a : ~a;
    if (enc == 1'b0) begin
      // enc0 has to change or the word lands on encoder 1
      if ({b, a} == {last_pins[2], last_pins[0]}) begin
        a = ~a;
        b = ~b;
      end
      return {1'($urandom), b, 1'($urandom), a};
    end
    // enc0 pins held so the word counts encoder 1
    return {b, last_pins[2], a, last_pins[0]};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // one input word: optional idle gap, then hold valid until taken
  task automatic send_word(input logic [dqmc_pkg::FUNC_BITS-1:0] f,
                           input logic [dqmc_pkg::PIN_BITS-1:0]  pins,
                           input logic                           m,
                           input logic [dqmc_pkg::DIST_BITS-1:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_pin_levels <= pins;
    in_motor_sel  <= m;
    in_distance   <= d;
    // ready is settled mid-cycle, the word goes at the next edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_results.push_back(predict_move_result(f, pins, m, d));
    words_sent++;
  endtask

  task automatic move_encoder(input logic enc, input logic up);
    send_word(dqmc_pkg::FUNC_SAMPLE, step_pins(enc, up), 1'($urandom), 31'($urandom));
  endtask

  task automatic check_motor(input logic m);
    send_word(dqmc_pkg::FUNC_CHECK, 4'($urandom), m, 31'($urandom));
  endtask

  task automatic arm_motor(input logic m, input logic [dqmc_pkg::DIST_BITS-1:0] d);
    send_word(dqmc_pkg::FUNC_ARM, 4'($urandom), m, d);
  endtask

  // sender holds off until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // counts straight after reset, pins at both extremes
  task automatic test_reset_values();
    send_word(dqmc_pkg::FUNC_SAMPLE, 4'hF, 1'b0, '0);
    send_word(dqmc_pkg::FUNC_SAMPLE, 4'h0, 1'b1, '1);
    check_motor(1'b0);
    check_motor(1'b1);
  endtask

  // the spare func code leaves everything alone
  task automatic test_unused_code();
    send_word(FUNC_UNUSED, 4'hA, 1'b1, '1);
    send_word(FUNC_UNUSED, 4'h5, 1'b0, 31'h2AAA_AAAA);
  endtask

  // start captured on first check, arrival up and down
  task automatic test_arm_and_arrival();
    arm_motor(1'b0, 31'd1);
    check_motor(1'b0);
    move_encoder(1'b0, 1'b1);
    check_motor(1'b0);
    arm_motor(1'b1, 31'd2);
    // movement before the first check is not counted
    move_encoder(1'b1, 1'b0);
    check_motor(1'b1);
    move_encoder(1'b1, 1'b0);
    move_encoder(1'b1, 1'b0);
    check_motor(1'b1);
  endtask

  // largest distance, zero distance disarm, re-arm drops the old start
  task automatic test_disarm_and_rearm();
    arm_motor(1'b1, '1);
    check_motor(1'b1);
    arm_motor(1'b1, '0);
    check_motor(1'b1);
    arm_motor(1'b0, 31'd2);
    check_motor(1'b0);
    move_encoder(1'b0, 1'b1);
    arm_motor(1'b0, 31'd2);
    check_motor(1'b0);
    move_encoder(1'b0, 1'b1);
    check_motor(1'b0);
    move_encoder(1'b0, 1'b1);
    check_motor(1'b0);
  endtask

  // mostly arm, move, poll until stop; some raw noise words in between
  task automatic test_move_traffic(input int unsigned n_words);
    int unsigned sent;
    int unsigned pick;
    int unsigned seq_len;
    logic m;
    logic up;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_word(2'($urandom), 4'($urandom), 1'($urandom), 31'($urandom));
        sent++;
      end else begin
        m = 1'($urandom);
        // a few long moves that end by disarm or the length cap
        arm_motor(m, (pick < 22) ? 31'($urandom) : 31'($urandom_range(6, 1)));
        sent++;
        up = 1'($urandom);
        seq_len = 0;
        while (move_span[m] != '0 && sent < n_words && seq_len < 40) begin
          pick = $urandom_range(99);
          if (pick < 55) begin
            move_encoder(m, ($urandom_range(99) < 80) ? up : ~up);
          end else if (pick < 62) begin
            move_encoder(~m, 1'($urandom));
          end else if (pick < 93) begin
            check_motor(m);
          end else if (pick < 96) begin
            arm_motor(m, (pick < 95) ? 31'($urandom_range(4, 1)) : '0);
          end else begin
            check_motor(~m);
          end
          sent++;
          seq_len++;
        end
      end
    end
  endtask

  // results are taken at the edge after the mid-cycle sample
  always @(negedge clk) begin : check_results
    move_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual stop=%b cnt0=%h cnt1=%h",
                 $time, out_stop, out_count_zero, out_count_one);
      end else begin
        want = pending_results.pop_front();
        if (want.stop) stops_seen++;
        check_field("stop", 32'(want.stop), 32'(out_stop));
        check_field("stopped_motor", 32'(want.motor), 32'(out_stopped_motor));
        check_field("count_zero", want.cnt0, out_count_zero);
        check_field("count_one", want.cnt1, out_count_one);
        check_field("armed_mask", 32'(want.armed), 32'(out_armed_mask));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("tb_dual_quadrature_move_counter_core: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= dqmc_pkg::FUNC_SAMPLE;
    in_pin_levels <= '0;
    in_motor_sel  <= 1'b0;
    in_distance   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with both sides always ready
    test_reset_values();
    test_unused_code();
    test_arm_and_arrival();
    test_disarm_and_rearm();

    // random part over four handshake mixes
    test_move_traffic(170);
    in_idle_pct = 60;
    out_stall_pct = 0;
    test_move_traffic(80);
    wait_drained();
    test_move_traffic(90);
    in_idle_pct = 0;
    out_stall_pct = 60;
    test_move_traffic(170);
    in_idle_pct = 26;
    out_stall_pct = 26;
    test_move_traffic(170);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words, checked %0d results, %0d of them arrivals", words_sent,
             results_seen, stops_seen);
    $display("mixes: free flow, sender gaps with a full drain, result stalls, both");
    if (mismatches == 0) begin
      $display("tb_dual_quadrature_move_counter_core: clean");
    end else begin
      $display("tb_dual_quadrature_move_counter_core: errors");
    end
    $finish;
  end

endmodule
